// ----- rtl/bfee_pkg.sv -----
// ----------------------------------------------------------------------------
// Byte FIFO with echo expander: shared definitions
// Result kinds, opcodes, terminal character codes and the request that the
// FIFO control hands to the echo sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bfee_pkg;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_ECHO   = 2'd1,
        KIND_EMPTY  = 2'd2
    } t_kind;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_BS    = 8'h08;

    localparam int OUT_TDATA_W = 24;

    typedef struct packed {
        logic       load;
        t_kind      kind;
        logic [7:0] data;
        logic       dropped;
        logic [7:0] fill;
    } t_emit_req;

endpackage

`default_nettype wire

// ----- rtl/byte_fifo_with_echo_expander.sv -----
// Timing: a push status or an empty-pop result is valid in the cycle after the
// input transfer; the first echo result of a pop passes the byte memory read
// register and then the output register. One item at a time: the next input
// transfer is taken the cycle after the item's last result transfer, which
// is set by the read of the byte memory and the echo sequencer.
// Reset: synchronous, active low; clears pointers, count and control only.
// ----------------------------------------------------------------------------
// Byte FIFO with echo expander
// Circular receive byte FIFO in a synchronous memory, with a terminal echo
// expander on the pop side.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_fifo_with_echo_expander
    import bfee_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: rx_byte [7:0]
    input  wire logic [7:0]             s_axis_tdata,
    // tuser: opcode [0]
    input  wire logic [0:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata: out_byte [7:0], dropped [8], fill_level [16:9], zero [23:17]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: kind [1:0]
    output logic [1:0]                  m_axis_tuser,
    output logic                        m_axis_tlast
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wp;
    logic [PTR_W-1:0] n_rp;
    logic [CNT_W-1:0] n_count;
    logic [7:0]       r_rd_data;
    logic [7:0]       mem [DEPTH];

    logic      accept;
    logic      is_push;
    logic      full;
    logic      empty;
    logic      wr_en;
    logic      rd_go;
    logic      emit_done;
    t_emit_req req;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_push       = (s_axis_tuser[0] == OP_PUSH);
    assign full          = (r_count == CNT_W'(DEPTH));
    assign empty         = (r_count == '0);
    assign wr_en         = accept && is_push && !full;
    assign rd_go         = accept && !is_push && !empty;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (wr_en) begin
            n_wp    = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            n_count = r_count + CNT_W'(1);
        end
        if (rd_go) begin
            n_rp    = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        req = '0;
        case (r_state)
            S_IDLE: begin
                if (accept && is_push) begin
                    req.load    = 1'b1;
                    req.kind    = KIND_STATUS;
                    req.dropped = full;
                    req.fill    = 8'(n_count);
                end else if (accept && empty) begin
                    req.load = 1'b1;
                    req.kind = KIND_EMPTY;
                end
            end
            S_READ: begin
                req.load = 1'b1;
                req.kind = KIND_ECHO;
                req.data = r_rd_data;
                req.fill = 8'(r_count);
            end
            default: begin
                req = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = rd_go ? S_READ : S_EMIT;
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (emit_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wp] <= s_axis_tdata;
        end
        r_rd_data <= mem[r_rp];
    end

    bfee_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .o_done        (emit_done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/bfee_emit.sv -----
// ----------------------------------------------------------------------------
// Echo sequencer
// Holds one result group in an output register and steps through the echo
// expansion of a popped byte, one result per output transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module bfee_emit
    import bfee_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_emit_req              i_req,
    output logic                        o_done,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata: out_byte [7:0], dropped [8], fill_level [16:9], zero [23:17]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: kind [1:0]
    output logic [1:0]                  m_axis_tuser,
    output logic                        m_axis_tlast
);

    logic       r_valid;
    logic [1:0] r_step;
    logic [1:0] r_last_idx;
    t_kind      r_kind;
    logic [7:0] r_char;
    logic       r_dropped;
    logic [7:0] r_fill;

    logic       n_valid;
    logic [1:0] n_step;
    logic [1:0] last_idx;
    logic       last_step;
    logic [7:0] out_byte;
    logic       xfer;

    always_comb begin
        last_idx = 2'd0;
        if (i_req.kind == KIND_ECHO) begin
            if (i_req.data == CH_CR) begin
                last_idx = 2'd1;
            end else if (i_req.data == CH_DEL || i_req.data == CH_BS) begin
                last_idx = 2'd2;
            end
        end
    end

    assign last_step = (r_step == r_last_idx);
    assign xfer      = r_valid && m_axis_tready;
    assign o_done    = xfer && last_step;

    always_comb begin
        case (r_step)
            2'd0:    out_byte = r_char;
            2'd1:    out_byte = (r_char == CH_CR) ? CH_LF : CH_SPACE;
            default: out_byte = r_char;
        endcase
        if (r_kind != KIND_ECHO) begin
            out_byte = 8'd0;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_step  = r_step;
        if (i_req.load) begin
            n_valid = 1'b1;
            n_step  = 2'd0;
        end else if (xfer) begin
            if (last_step) begin
                n_valid = 1'b0;
            end else begin
                n_step = r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.load) begin
            r_kind     <= i_req.kind;
            r_char     <= i_req.data;
            r_dropped  <= i_req.dropped;
            r_fill     <= i_req.fill;
            r_last_idx <= last_idx;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {7'd0, r_fill, r_dropped, out_byte};
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = last_step;

endmodule

`default_nettype wire

// ----- rtl/bfee_checker.sv -----
// ----------------------------------------------------------------------------
// Byte FIFO with echo expander: port checker
// Watches the stream ports of the top level and flags sequencing errors.
// ----------------------------------------------------------------------------
`default_nettype none

module bfee_checker
    import bfee_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [0:0]             s_axis_tuser,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [1:0]             m_axis_tuser,
    input wire logic                   m_axis_tlast
);

    logic s_xfer;
    logic m_xfer;

    assign s_xfer = s_axis_tvalid && s_axis_tready;
    assign m_xfer = m_axis_tvalid && m_axis_tready;

    // The block never takes a new item while a result is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // A push transfer is answered by a status result in the next cycle.
    a_push_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && s_axis_tuser[0] == OP_PUSH) |=>
        (m_axis_tvalid && m_axis_tuser == KIND_STATUS && m_axis_tlast))
        else $error("push transfer without status result");

    // Status and empty results are single and carry no byte.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_ECHO) |->
        (m_axis_tlast && m_axis_tdata[7:0] == 8'd0))
        else $error("non-echo result with byte or without last");

    // A non-final echo result is followed by another echo result.
    a_echo_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_xfer && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tuser == KIND_ECHO && !m_axis_tdata[8]))
        else $error("echo sequence broken");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
         && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind byte_fifo_with_echo_expander bfee_checker u_bfee_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
